@@ hdl/sidta_pkg.sv @@
// Shared types, constants and helpers for the signed integer to decimal ASCII block.
// No dependencies.
`default_nettype none
package sidta_pkg;

  localparam int DEFAULT_VALUE_BITS = 32;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } sidta_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sidta_qstat_t;

  // decimal digits needed for any unsigned value of the given width
  function automatic int sidta_digits(input int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

endpackage
`default_nettype wire

@@ hdl/sidta_front.sv @@
// Front stage: accept a word, split it into sign and magnitude, hand it to the queue.
// Depends on sidta_pkg.
`default_nettype none
module sidta_front #(
  parameter int VALUE_BITS = sidta_pkg::DEFAULT_VALUE_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [VALUE_BITS-1:0]    value,
  input  wire sidta_pkg::sidta_qstat_t  qstat,
  output logic                          push,
  output logic                          push_neg,
  output logic [VALUE_BITS-1:0]         push_mag
);
  import sidta_pkg::*;

  logic                  valid;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  accept;

  assign busy     = valid && qstat.full;
  assign accept   = start && !busy;
  assign push     = valid && !qstat.full;
  assign push_neg = neg;
  assign push_mag = mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= value[VALUE_BITS-1];
      mag <= value[VALUE_BITS-1] ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;
    end
  end

endmodule
`default_nettype wire

@@ hdl/sidta_queue.sv @@
// Two-entry queue of sign/magnitude words between front and back.
// Depends on sidta_pkg.
`default_nettype none
module sidta_queue #(
  parameter int VALUE_BITS = sidta_pkg::DEFAULT_VALUE_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire logic                     push_neg,
  input  wire logic [VALUE_BITS-1:0]    push_mag,
  input  wire logic                     pop,
  output logic                          pop_neg,
  output logic [VALUE_BITS-1:0]         pop_mag,
  output sidta_pkg::sidta_qstat_t       qstat
);
  import sidta_pkg::*;

  logic [VALUE_BITS:0] entry [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                do_push;
  logic                do_pop;

  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_neg     = entry[rd_ptr][VALUE_BITS];
  assign pop_mag     = entry[rd_ptr][VALUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= {push_neg, push_mag};
    end
  end

endmodule
`default_nettype wire

@@ hdl/sidta_back.sv @@
// Back stage: bit-serial binary to BCD, sign if negative, then one digit per cycle.
// Depends on sidta_pkg.
`default_nettype none
module sidta_back #(
  parameter int VALUE_BITS = sidta_pkg::DEFAULT_VALUE_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire sidta_pkg::sidta_qstat_t  qstat,
  input  wire logic                     pop_neg,
  input  wire logic [VALUE_BITS-1:0]    pop_mag,
  output logic                          pop,
  output logic                          strobe,
  output logic [7:0]                    char_code,
  output logic                          is_last
);
  import sidta_pkg::*;

  localparam int DIGITS = sidta_digits(VALUE_BITS);
  localparam int BCD_W  = 4 * DIGITS;
  localparam int BCW    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int RCW    = $clog2(DIGITS + 1);

  sidta_state_t          state;
  sidta_state_t          state_next;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [BCW-1:0]        bit_cnt;
  logic [RCW-1:0]        remain;
  logic [3:0]            top;
  logic                  conv_done;
  logic                  lead_done;

  assign top       = bcd[BCD_W-1 -: 4];
  assign conv_done = (bit_cnt == BCW'(VALUE_BITS - 1));
  assign lead_done = (top != 4'd0) || (remain == RCW'(1));

  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? (bcd[4*d +: 4] + 4'd3) : bcd[4*d +: 4];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (!qstat.empty) state_next = ST_CONVERT;
      ST_CONVERT: if (conv_done) state_next = neg ? ST_SIGN : ST_SKIP;
      ST_SIGN:    state_next = ST_SKIP;
      ST_SKIP:    if (lead_done) state_next = ST_EMIT;
      ST_EMIT:    if (remain == RCW'(1)) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    strobe    = 1'b0;
    is_last   = 1'b0;
    char_code = ASCII_ZERO + {4'd0, top};
    case (state)
      ST_IDLE: begin
        pop = !qstat.empty;
      end
      ST_SIGN: begin
        strobe    = 1'b1;
        char_code = ASCII_MINUS;
      end
      ST_EMIT: begin
        strobe  = 1'b1;
        is_last = (remain == RCW'(1));
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        neg     <= pop_neg;
        mag     <= pop_mag;
        bcd     <= '0;
        bit_cnt <= '0;
        remain  <= RCW'(DIGITS);
      end
      ST_CONVERT: begin
        bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_BITS-1]};
        mag     <= mag << 1;
        bit_cnt <= bit_cnt + BCW'(1);
      end
      ST_SKIP: begin
        if (!lead_done) begin
          bcd    <= bcd << 4;
          remain <= remain - RCW'(1);
        end
      end
      ST_EMIT: begin
        bcd    <= bcd << 4;
        remain <= remain - RCW'(1);
      end
      default: begin
        bcd <= bcd;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/signed_int_to_decimal_ascii.sv @@
// Top level: signed integer to decimal ASCII text, front stage, queue and converter.
// Depends on sidta_pkg, sidta_front, sidta_queue, sidta_back.
//
// Channel  Handshake                 Payload
// input    start / busy              value
// output   strobe (one cycle each)   char_code, is_last
//
// A word passes through a load state, the bit-serial converter, a sign state if negative,
// then a search for the first digit that skips leading zero positions, then the digits.
// The converter sets the rate; the two-entry queue and front register let up to
// three words wait. busy rises only when all are taken. Reset is synchronous and
// clears valid flag, queue pointers and FSM state; the output side is never stalled.
`default_nettype none
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sidta_pkg::DEFAULT_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic                       strobe,
  output logic [7:0]                 char_code,
  output logic                       is_last
);
  import sidta_pkg::*;

  sidta_qstat_t          qstat;
  logic                  push;
  logic                  push_neg;
  logic [VALUE_BITS-1:0] push_mag;
  logic                  pop;
  logic                  pop_neg;
  logic [VALUE_BITS-1:0] pop_mag;

  sidta_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .value    (value),
    .qstat    (qstat),
    .push     (push),
    .push_neg (push_neg),
    .push_mag (push_mag)
  );

  sidta_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_neg (push_neg),
    .push_mag (push_mag),
    .pop      (pop),
    .pop_neg  (pop_neg),
    .pop_mag  (pop_mag),
    .qstat    (qstat)
  );

  sidta_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .pop_neg   (pop_neg),
    .pop_mag   (pop_mag),
    .pop       (pop),
    .strobe    (strobe),
    .char_code (char_code),
    .is_last   (is_last)
  );

endmodule
`default_nettype wire

@@ hdl/sidta_checker.sv @@
// Port-level checks for signed_int_to_decimal_ascii, attached by bind.
// Depends on sidta_pkg and the top level's ports.
`default_nettype none
module sidta_checker #(
  parameter int VALUE_BITS = sidta_pkg::DEFAULT_VALUE_BITS
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic [VALUE_BITS-1:0] value,
  input wire logic                  strobe,
  input wire logic [7:0]            char_code,
  input wire logic                  is_last
);
  import sidta_pkg::*;

  logic [7:0] digit_max;
  assign digit_max = ASCII_ZERO + 8'd9;

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (char_code == ASCII_MINUS) ||
               ((char_code >= ASCII_ZERO) && (char_code <= digit_max) && (value == value)))
    else $error("character outside sign and digit set");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (char_code == ASCII_MINUS)) |-> !is_last)
    else $error("sign marked as last character");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && is_last) |=> !strobe)
    else $error("character right after the last one");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!strobe && !busy && !(start && 1'b0)))
    else $error("activity right after reset");

endmodule

bind signed_int_to_decimal_ascii sidta_checker #(.VALUE_BITS(VALUE_BITS)) u_sidta_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .value     (value),
  .strobe    (strobe),
  .char_code (char_code),
  .is_last   (is_last)
);
`default_nettype wire
